// ----- design/mse_pkg.sv -----
// mse_pkg: shared types, opcodes and sizes for the MIPS subset execute block
// used by mips_subset_execute, mse_front and mse_back; depends on nothing
`default_nettype none

package mse_pkg;

    localparam int DATA_WORDS = 4096;
    localparam int DATA_AW    = $clog2(DATA_WORDS);
    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int INQ_DEPTH  = 2;
    localparam int INQ_PW     = $clog2(INQ_DEPTH);
    localparam int INQ_CW     = $clog2(INQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [31:0] TEXT_START_RESET = 32'h0040_0000;

    // configuration register indexes (paddr bit 2)
    localparam logic CFG_TEXT_START  = 1'b0;
    localparam logic CFG_INSTR_COUNT = 1'b1;

    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTIU   = 6'h0b;
    localparam logic [5:0] OPC_ANDI    = 6'h0c;
    localparam logic [5:0] OPC_ORI     = 6'h0d;
    localparam logic [5:0] OPC_LUI     = 6'h0f;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_LUI,
        ALU_LINK
    } alu_op_t;

    typedef enum logic [1:0] {
        OPB_REG,
        OPB_SEXT,
        OPB_ZEXT
    } opb_sel_t;

    typedef struct packed {
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dst;
        logic [4:0]  shamt;
        logic [15:0] imm;
        logic [25:0] target;
        alu_op_t     alu_op;
        opb_sel_t    opb_sel;
        logic        wr;
        logic        load;
        logic        store;
        logic        beq;
        logic        bne;
        logic        jump;
        logic        jr;
        logic        unsup;
    } uop_t;

    typedef struct packed {
        logic valid;
        uop_t uop;
    } issue_req_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        store_done;
        logic [31:0] store_address;
        logic [31:0] store_value;
        logic        unsupported;
    } result_t;

endpackage

`default_nettype wire

// ----- design/mips_subset_execute.sv -----
// mips_subset_execute: top level, configuration registers and APB port
// uses mse_pkg, mse_front and mse_back
`default_nettype none

// Executes one MIPS-32 subset instruction per item and returns one result item for
// each. A new item is taken every clock cycle in steady state, while full is low and
// results are popped; each item passes the input queue, execute, memory read, then
// the result queue. The data store read completes in the memory stage; register
// operands are forwarded, so dependent instructions need no gap. After reset the
// data store is cleared one word per cycle, all DATA_WORDS (4096) words, while full
// stays high; configuration writes are taken at all times.
module mips_subset_execute
    import mse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] instr_word,
    output logic             empty,
    input  wire logic        pop,
    output logic      [31:0] next_pc,
    output logic             halted,
    output logic             reg_written,
    output logic      [4:0]  reg_index,
    output logic      [31:0] reg_value,
    output logic             store_done,
    output logic      [31:0] store_address,
    output logic      [31:0] store_value,
    output logic             unsupported
);

    logic [31:0] text_start_reg;
    logic [16:0] icount_reg;
    logic [31:0] end_addr_reg;
    logic        cfg_we;
    issue_req_t  head;
    logic        issue;
    logic        clearing;
    result_t     res;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_INSTR_COUNT) ? {15'd0, icount_reg} : text_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_start_reg <= TEXT_START_RESET;
            icount_reg     <= '0;
            end_addr_reg   <= TEXT_START_RESET;
        end
        else
        begin
            if (cfg_we && (paddr[2] == CFG_TEXT_START))
            begin
                text_start_reg <= pwdata;
            end
            if (cfg_we && (paddr[2] == CFG_INSTR_COUNT))
            begin
                icount_reg <= pwdata[16:0];
            end
            // halt address, wraps modulo 2^32
            end_addr_reg <= text_start_reg + {13'd0, icount_reg, 2'b00};
        end
    end

    mse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .instr_word (instr_word),
        .blocked    (clearing),
        .issue      (issue),
        .head       (head)
    );

    mse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .issue    (issue),
        .clearing (clearing),
        .end_addr (end_addr_reg),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

    assign next_pc       = res.next_pc;
    assign halted        = res.halted;
    assign reg_written   = res.reg_written;
    assign reg_index     = res.reg_index;
    assign reg_value     = res.reg_value;
    assign store_done    = res.store_done;
    assign store_address = res.store_address;
    assign store_value   = res.store_value;
    assign unsupported   = res.unsupported;

endmodule

`default_nettype wire

// ----- design/mse_ram.sv -----
// mse_ram: generic one-write one-read RAM with registered read data
// read returns the old contents on a same-address write; no dependencies
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/mse_front.sv -----
// mse_front: accepts instruction words, decodes them and holds them in a short queue
// uses mse_pkg
`default_nettype none

module mse_front
    import mse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] instr_word,
    input  wire logic        blocked,
    input  wire logic        issue,
    output issue_req_t       head
);

    uop_t               dec;
    logic [5:0]         opc;
    logic [5:0]         fn;
    logic               accept;
    uop_t               q_mem_reg [INQ_DEPTH];
    logic [INQ_PW-1:0]  wr_ptr_reg;
    logic [INQ_PW-1:0]  rd_ptr_reg;
    logic [INQ_CW-1:0]  count_reg;
    logic [INQ_CW-1:0]  count_next;

    assign opc = instr_word[31:26];
    assign fn  = instr_word[5:0];

    always_comb
    begin
        dec         = '0;
        dec.rs      = instr_word[25:21];
        dec.rt      = instr_word[20:16];
        dec.dst     = instr_word[20:16];
        dec.shamt   = instr_word[10:6];
        dec.imm     = instr_word[15:0];
        dec.target  = instr_word[25:0];
        dec.alu_op  = ALU_ADD;
        dec.opb_sel = OPB_REG;
        case (opc)
            OPC_SPECIAL:
            begin
                dec.dst = instr_word[15:11];
                dec.wr  = 1'b1;
                case (fn)
                    FN_ADDU: dec.alu_op = ALU_ADD;
                    FN_SUBU: dec.alu_op = ALU_SUB;
                    FN_AND:  dec.alu_op = ALU_AND;
                    FN_OR:   dec.alu_op = ALU_OR;
                    FN_NOR:  dec.alu_op = ALU_NOR;
                    FN_SLTU: dec.alu_op = ALU_SLTU;
                    FN_SLL:  dec.alu_op = ALU_SLL;
                    FN_SRL:  dec.alu_op = ALU_SRL;
                    FN_JR:
                    begin
                        dec.wr = 1'b0;
                        dec.jr = 1'b1;
                    end
                    default:
                    begin
                        dec.wr    = 1'b0;
                        dec.unsup = 1'b1;
                    end
                endcase
            end
            OPC_ADDIU:
            begin
                dec.wr      = 1'b1;
                dec.opb_sel = OPB_SEXT;
            end
            OPC_SLTIU:
            begin
                dec.wr      = 1'b1;
                dec.alu_op  = ALU_SLTU;
                dec.opb_sel = OPB_SEXT;
            end
            OPC_ANDI:
            begin
                dec.wr      = 1'b1;
                dec.alu_op  = ALU_AND;
                dec.opb_sel = OPB_ZEXT;
            end
            OPC_ORI:
            begin
                dec.wr      = 1'b1;
                dec.alu_op  = ALU_OR;
                dec.opb_sel = OPB_ZEXT;
            end
            OPC_LUI:
            begin
                dec.wr     = 1'b1;
                dec.alu_op = ALU_LUI;
            end
            OPC_LW:
            begin
                dec.wr      = 1'b1;
                dec.load    = 1'b1;
                dec.opb_sel = OPB_SEXT;
            end
            OPC_SW:
            begin
                dec.store   = 1'b1;
                dec.opb_sel = OPB_SEXT;
            end
            OPC_BEQ: dec.beq = 1'b1;
            OPC_BNE: dec.bne = 1'b1;
            OPC_J:   dec.jump = 1'b1;
            OPC_JAL:
            begin
                dec.jump   = 1'b1;
                dec.wr     = 1'b1;
                dec.dst    = 5'd31;
                dec.alu_op = ALU_LINK;
            end
            default: dec.unsup = 1'b1;
        endcase
        // register zero is never written
        if (dec.dst == 5'd0)
        begin
            dec.wr = 1'b0;
        end
    end

    assign full   = (count_reg == INQ_CW'(INQ_DEPTH)) || blocked;
    assign accept = push && !full;

    assign head.valid = (count_reg != '0);
    assign head.uop   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (accept && !issue)
        begin
            count_next = count_reg + INQ_CW'(1);
        end
        else if (!accept && issue)
        begin
            count_next = count_reg - INQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + INQ_PW'(1);
            end
            if (issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + INQ_PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ----- design/mse_back.sv -----
// mse_back: execute and memory stages, register file, data store and result queue
// uses mse_pkg and mse_ram
`default_nettype none

module mse_back
    import mse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  issue_req_t       head,
    output logic             issue,
    output logic             clearing,
    input  wire logic [31:0] end_addr,
    output logic             empty,
    input  wire logic        pop,
    output result_t          res
);

    // execute stage
    logic               x_valid_reg;
    uop_t               x_uop_reg;
    logic               rs_ok_reg;
    logic               rt_ok_reg;
    logic [31:0]        pc_reg;
    logic [31:0]        rf_a_rdata;
    logic [31:0]        rf_b_rdata;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        simm;
    logic [31:0]        opb;
    logic [31:0]        sum;
    logic [31:0]        alu;
    logic [31:0]        pc_plus4;
    logic [31:0]        npc;
    logic               taken;
    logic [DATA_AW-1:0] word_idx;
    result_t            x_res;

    // memory stage
    logic               m_valid_reg;
    logic               m_load_reg;
    result_t            m_res_reg;
    logic [31:0]        dram_rdata;
    logic [31:0]        m_wdata;
    logic               rf_we;
    result_t            m_res;

    logic               wbl_valid_reg;
    logic [4:0]         wbl_idx_reg;
    logic [31:0]        wbl_val_reg;
    logic [REG_COUNT-1:0] rf_valid_reg;

    logic               clearing_reg;
    logic [DATA_AW-1:0] clr_cnt_reg;
    logic               dram_we;
    logic [DATA_AW-1:0] dram_waddr;
    logic [31:0]        dram_wdata;

    // result queue
    result_t              oq_mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PW-1:0]   oq_wr_ptr_reg;
    logic [OUTQ_PW-1:0]   oq_rd_ptr_reg;
    logic [OUTQ_CW-1:0]   oq_count_reg;
    logic [OUTQ_CW-1:0]   oq_occ;
    logic                 oq_pop;

    assign clearing = clearing_reg;

    // reserve a result slot for every item in flight so the pipe never stalls
    assign oq_occ = oq_count_reg + OUTQ_CW'(x_valid_reg) + OUTQ_CW'(m_valid_reg);
    assign issue  = head.valid && !clearing_reg && (oq_occ < OUTQ_CW'(OUTQ_DEPTH));

    mse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (m_res_reg.reg_index),
        .wdata (m_wdata),
        .raddr (head.uop.rs),
        .rdata (rf_a_rdata)
    );

    mse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (m_res_reg.reg_index),
        .wdata (m_wdata),
        .raddr (head.uop.rt),
        .rdata (rf_b_rdata)
    );

    assign m_wdata = m_load_reg ? dram_rdata : m_res_reg.reg_value;
    assign rf_we   = m_valid_reg && m_res_reg.reg_written;

    // operands: newest write first, then the write that landed at the read edge
    always_comb
    begin
        if (rf_we && (m_res_reg.reg_index == x_uop_reg.rs))
        begin
            a = m_wdata;
        end
        else if (wbl_valid_reg && (wbl_idx_reg == x_uop_reg.rs))
        begin
            a = wbl_val_reg;
        end
        else
        begin
            a = rs_ok_reg ? rf_a_rdata : 32'd0;
        end
        if (rf_we && (m_res_reg.reg_index == x_uop_reg.rt))
        begin
            b = m_wdata;
        end
        else if (wbl_valid_reg && (wbl_idx_reg == x_uop_reg.rt))
        begin
            b = wbl_val_reg;
        end
        else
        begin
            b = rt_ok_reg ? rf_b_rdata : 32'd0;
        end
    end

    assign simm = {{16{x_uop_reg.imm[15]}}, x_uop_reg.imm};

    always_comb
    begin
        case (x_uop_reg.opb_sel)
            OPB_SEXT: opb = simm;
            OPB_ZEXT: opb = {16'd0, x_uop_reg.imm};
            default:  opb = b;
        endcase
    end

    assign sum      = a + opb;
    assign pc_plus4 = pc_reg + 32'd4;
    assign word_idx = sum[DATA_AW+1:2];

    always_comb
    begin
        case (x_uop_reg.alu_op)
            ALU_ADD:  alu = sum;
            ALU_SUB:  alu = a - opb;
            ALU_AND:  alu = a & opb;
            ALU_OR:   alu = a | opb;
            ALU_NOR:  alu = ~(a | opb);
            ALU_SLTU: alu = {31'd0, (a < opb)};
            ALU_SLL:  alu = b << x_uop_reg.shamt;
            ALU_SRL:  alu = b >> x_uop_reg.shamt;
            ALU_LUI:  alu = {x_uop_reg.imm, 16'd0};
            ALU_LINK: alu = pc_reg + 32'd8;
            default:  alu = sum;
        endcase
    end

    assign taken = (x_uop_reg.beq && (a == b)) || (x_uop_reg.bne && (a != b));

    always_comb
    begin
        if (x_uop_reg.jr)
        begin
            npc = a;
        end
        else if (x_uop_reg.jump)
        begin
            npc = {4'd0, x_uop_reg.target, 2'b00};
        end
        else if (taken)
        begin
            npc = pc_plus4 + {simm[29:0], 2'b00};
        end
        else
        begin
            npc = pc_plus4;
        end
    end

    always_comb
    begin
        x_res               = '0;
        x_res.next_pc       = npc;
        x_res.halted        = (npc == end_addr);
        x_res.reg_written   = x_uop_reg.wr;
        x_res.unsupported   = x_uop_reg.unsup;
        if (x_uop_reg.wr)
        begin
            x_res.reg_index = x_uop_reg.dst;
            x_res.reg_value = alu;
        end
        if (x_uop_reg.store)
        begin
            x_res.store_done    = 1'b1;
            x_res.store_address = sum;
            x_res.store_value   = b;
        end
    end

    // data store: clearing pass owns the write port after reset
    assign dram_we    = clearing_reg || (x_valid_reg && x_uop_reg.store);
    assign dram_waddr = clearing_reg ? clr_cnt_reg : word_idx;
    assign dram_wdata = clearing_reg ? 32'd0 : b;

    mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dram (
        .clk   (clk),
        .we    (dram_we),
        .waddr (dram_waddr),
        .wdata (dram_wdata),
        .raddr (word_idx),
        .rdata (dram_rdata)
    );

    always_comb
    begin
        m_res = m_res_reg;
        if (m_load_reg && m_res_reg.reg_written)
        begin
            m_res.reg_value = dram_rdata;
        end
    end

    assign empty  = (oq_count_reg == '0);
    assign oq_pop = pop && !empty;
    assign res    = oq_mem_reg[oq_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            wbl_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            pc_reg        <= TEXT_START_RESET;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            x_valid_reg   <= issue;
            m_valid_reg   <= x_valid_reg;
            wbl_valid_reg <= rf_we;
            if (rf_we)
            begin
                rf_valid_reg[m_res_reg.reg_index] <= 1'b1;
            end
            if (x_valid_reg)
            begin
                pc_reg <= npc;
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + DATA_AW'(1);
                if (clr_cnt_reg == DATA_AW'(DATA_WORDS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (m_valid_reg)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + OUTQ_PW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OUTQ_PW'(1);
            end
            if (m_valid_reg && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + OUTQ_CW'(1);
            end
            else if (!m_valid_reg && oq_pop)
            begin
                oq_count_reg <= oq_count_reg - OUTQ_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_uop_reg   <= head.uop;
        rs_ok_reg   <= rf_valid_reg[head.uop.rs];
        rt_ok_reg   <= rf_valid_reg[head.uop.rt];
        m_res_reg   <= x_res;
        m_load_reg  <= x_uop_reg.load;
        wbl_idx_reg <= m_res_reg.reg_index;
        wbl_val_reg <= m_wdata;
        if (m_valid_reg)
        begin
            oq_mem_reg[oq_wr_ptr_reg] <= m_res;
        end
    end

endmodule

`default_nettype wire

// ----- design/mse_checker.sv -----
// mse_checker: port-level checks on result items of mips_subset_execute
// bound to the top level below; no package needed
`default_nettype none

module mse_port_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        reg_written,
    input wire logic [4:0]  reg_index,
    input wire logic [31:0] reg_value,
    input wire logic        store_done,
    input wire logic [31:0] store_address,
    input wire logic [31:0] store_value,
    input wire logic        unsupported,
    input wire logic [31:0] next_pc
);

    // an unsupported item is a no-op
    a_unsup_noop: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && unsupported) |-> (!reg_written && !store_done))
        else $error("unsupported item changed state");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !reg_written) |-> ((reg_index == 5'd0) && (reg_value == 32'd0)))
        else $error("register fields not zero without a write");

    a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reg_written) |-> (reg_index != 5'd0))
        else $error("write reported to register zero");

    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !store_done) |-> ((store_address == 32'd0) && (store_value == 32'd0)))
        else $error("store fields not zero without a store");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(next_pc)))
        else $error("waiting result item changed");

endmodule

bind mips_subset_execute mse_port_props u_mse_port_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .reg_written   (reg_written),
    .reg_index     (reg_index),
    .reg_value     (reg_value),
    .store_done    (store_done),
    .store_address (store_address),
    .store_value   (store_value),
    .unsupported   (unsupported),
    .next_pc       (next_pc)
);

`default_nettype wire
